// ===== src/lgbp_pkg.sv =====
// Shared types, constants and helpers for the local + gshare branch predictor.
// No dependencies; every other file imports this package.
`default_nettype none

package lgbp_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int LHIST_MAX     = 4;
    localparam int PER_ENTRY     = 1 << LHIST_MAX;
    localparam int CTR_W         = 2;
    localparam int LROW_W        = CTR_W * PER_ENTRY;
    localparam int FILL_W        = 3;
    localparam int LEN_W         = 3;
    localparam int WARM_W        = 6;
    localparam int ADDR_W        = 64;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = WARM_W;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CTR_W-1:0]  CTR_INIT        = 2'd1;
    localparam logic [CTR_W-1:0]  CTR_MAX         = 2'd3;
    localparam logic [LROW_W-1:0] LROW_INIT       = {PER_ENTRY{CTR_INIT}};
    localparam logic [LEN_W-1:0]  LOCAL_LEN_RST   = 3'd4;
    localparam logic [WARM_W-1:0] GLOBAL_WARM_RST = 6'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCAL_LEN     = 1'b0,
        REG_GLOBAL_WARMUP = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_FETCH,
        BK_UPDATE
    } t_back_state;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_addr;
        logic              taken;
    } t_in;

    typedef struct packed {
        logic local_prediction;
        logic local_correct;
        logic local_ready;
        logic global_prediction;
        logic global_correct;
        logic global_ready;
    } t_out;

    // One classified branch as it travels from front to back.
    typedef struct packed {
        logic [IDX_W-1:0] lidx;
        logic [IDX_W-1:0] gidx;
        logic             taken;
        logic             gready;
    } t_job;

    typedef struct packed {
        logic [FILL_W-1:0]    fill;
        logic [LHIST_MAX-1:0] pattern;
    } t_hist;

    // Queue status seen by the top level and the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                   input logic up);
        logic [CTR_W-1:0] r;
        if (up) begin
            r = (c < CTR_MAX) ? c + CTR_W'(1) : CTR_MAX;
        end else begin
            r = (c != '0) ? c - CTR_W'(1) : '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lgbp_front.sv =====
// Front end: classifies each accepted branch into table indexes and gshare readiness.
// Holds the global history and the global warm-up count. Depends on lgbp_pkg.
`default_nettype none

module lgbp_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  lgbp_pkg::t_in                i_item,
    input  wire [lgbp_pkg::WARM_W-1:0]   i_warmup,
    output lgbp_pkg::t_job               o_job
);
    import lgbp_pkg::*;

    logic [IDX_W-1:0]  r_ghist, n_ghist;
    logic [WARM_W-1:0] r_gfill, n_gfill;
    logic [WARM_W:0]   w_fill_inc;

    always_comb begin
        o_job.lidx   = i_item.branch_addr[IDX_W-1:0];
        o_job.gidx   = i_item.branch_addr[IDX_W-1:0] ^ r_ghist;
        o_job.taken  = i_item.taken;
        o_job.gready = (r_gfill >= i_warmup);

        // shift in every outcome; saturate the fill at the warm-up length
        n_ghist    = IDX_W'({r_ghist, i_item.taken});
        w_fill_inc = {1'b0, r_gfill} + (WARM_W + 1)'(1);
        n_gfill    = (w_fill_inc < {1'b0, i_warmup}) ? w_fill_inc[WARM_W-1:0] : i_warmup;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist <= '0;
            r_gfill <= '0;
        end else if (i_accept) begin
            r_ghist <= n_ghist;
            r_gfill <= n_gfill;
        end
    end

endmodule

`default_nettype wire

// ===== src/lgbp_fifo.sv =====
// Short job queue between the front end and the back end.
// Depends on lgbp_pkg for the job type and depth.
`default_nettype none

module lgbp_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  lgbp_pkg::t_job        i_job,
    input  wire                   i_pop,
    output lgbp_pkg::t_job        o_head,
    output lgbp_pkg::t_fifo_stat  o_stat
);
    import lgbp_pkg::*;

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr, r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_push, w_pop;

    function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
        w_push       = i_push && !o_stat.full;
        w_pop        = i_pop && !o_stat.empty;
        o_head       = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (w_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/lgbp_back.sv =====
// Back end: owns the history and counter memories, clears them after reset,
// and runs one read-modify-write per job. Depends on lgbp_pkg.
`default_nettype none

module lgbp_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  lgbp_pkg::t_job              i_job,
    input  lgbp_pkg::t_fifo_stat        i_stat,
    input  wire [lgbp_pkg::LEN_W-1:0]   i_local_len,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_done,
    output lgbp_pkg::t_out              o_result
);
    import lgbp_pkg::*;

    // memories: one history row, one local counter row and one gshare counter per entry
    t_hist             r_hist_mem [TABLE_ENTRIES];
    logic [LROW_W-1:0] r_lrow_mem [TABLE_ENTRIES];
    logic [CTR_W-1:0]  r_gctr_mem [TABLE_ENTRIES];

    t_hist             r_hist_rd;
    logic [LROW_W-1:0] r_lrow_rd;
    logic [CTR_W-1:0]  r_gctr_rd;

    t_back_state       r_state, n_state;
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr;
    logic              r_done, n_done;
    t_out              r_result, n_result;

    logic              w_rd_en, w_we;
    logic [IDX_W-1:0]  w_laddr, w_gaddr;
    t_hist             w_hist_wr;
    logic [LROW_W-1:0] w_lrow_wr;
    logic [CTR_W-1:0]  w_gctr_wr;

    logic [LEN_W-1:0]     w_len;
    logic                 w_lready;
    logic [LHIST_MAX-1:0] w_mask, w_sel;
    logic [CTR_W-1:0]     w_lctr;
    logic                 w_lpred, w_gpred;
    t_hist                w_hist_upd;
    logic [LROW_W-1:0]    w_lrow_upd;
    logic [CTR_W-1:0]     w_gctr_upd;

    // local and gshare update from the registered read data
    always_comb begin
        w_len    = (i_local_len > LEN_W'(LHIST_MAX)) ? LEN_W'(LHIST_MAX) : i_local_len;
        w_lready = (r_hist_rd.fill >= w_len);
        for (int i = 0; i < LHIST_MAX; i++) begin
            w_mask[i] = (LEN_W'(i) < w_len);
        end
        w_sel   = r_hist_rd.pattern & w_mask;
        w_lctr  = r_lrow_rd[w_sel * CTR_W +: CTR_W];
        w_lpred = w_lready && w_lctr[CTR_W-1];

        w_lrow_upd = r_lrow_rd;
        if (w_lready) begin
            w_lrow_upd[w_sel * CTR_W +: CTR_W] = ctr_train(w_lctr, i_job.taken);
        end
        w_hist_upd.fill    = w_lready ? r_hist_rd.fill : r_hist_rd.fill + FILL_W'(1);
        w_hist_upd.pattern = LHIST_MAX'({r_hist_rd.pattern, i_job.taken});

        w_gpred    = i_job.gready && r_gctr_rd[CTR_W-1];
        w_gctr_upd = i_job.gready ? ctr_train(r_gctr_rd, i_job.taken) : r_gctr_rd;
    end

    // sequencer: clear pass, then fetch / update per job
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_done     = 1'b0;
        n_result   = r_result;
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_we       = 1'b0;
        w_laddr    = i_job.lidx;
        w_gaddr    = i_job.gidx;
        w_hist_wr  = w_hist_upd;
        w_lrow_wr  = w_lrow_upd;
        w_gctr_wr  = w_gctr_upd;
        unique case (r_state)
            BK_CLEAR: begin
                w_we       = 1'b1;
                w_laddr    = r_clr_addr;
                w_gaddr    = r_clr_addr;
                w_hist_wr  = '0;
                w_lrow_wr  = LROW_INIT;
                w_gctr_wr  = CTR_INIT;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (!i_stat.empty) begin
                    w_rd_en = 1'b1;
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                w_we                       = 1'b1;
                o_pop                      = 1'b1;
                n_done                     = 1'b1;
                n_result.local_prediction  = w_lpred;
                n_result.local_correct     = (w_lpred == i_job.taken);
                n_result.local_ready       = w_lready;
                n_result.global_prediction = w_gpred;
                n_result.global_correct    = (w_gpred == i_job.taken);
                n_result.global_ready      = i_job.gready;
                n_state                    = BK_FETCH;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hist_mem[w_laddr] <= w_hist_wr;
            r_lrow_mem[w_laddr] <= w_lrow_wr;
            r_gctr_mem[w_gaddr] <= w_gctr_wr;
        end
        if (w_rd_en) begin
            r_hist_rd <= r_hist_mem[w_laddr];
            r_lrow_rd <= r_lrow_mem[w_laddr];
            r_gctr_rd <= r_gctr_mem[w_gaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_clearing = (r_state == BK_CLEAR);
    assign o_done     = r_done;
    assign o_result   = r_result;

endmodule

`default_nettype wire

// ===== src/local_and_gshare_branch_predictor.sv =====
// Top level: local two-level predictor and gshare trained side by side.
// Result strobe o_done is registered after the back end's fetch and update states, held 1 cycle.
// The back end works on one branch at a time: a fetch state, then an update state (read-then-write pass).
// A 2-entry queue lets start be taken while the back end works.
// Reset: synchronous; afterwards busy stays high through the table clear pass over all 1024 entries.
// Depends on lgbp_pkg, lgbp_front, lgbp_fifo, lgbp_back.
`default_nettype none

module local_and_gshare_branch_predictor (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  lgbp_pkg::t_in                    i_item,
    input  wire                              i_cfg_we,
    input  wire [lgbp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [lgbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_done,
    output lgbp_pkg::t_out                   o_result
);
    import lgbp_pkg::*;

    logic [LEN_W-1:0]  r_local_len;
    logic [WARM_W-1:0] r_global_warmup;

    logic       w_accept;
    logic       w_pop;
    logic       w_clearing;
    t_job       w_job_in;
    t_job       w_job_head;
    t_fifo_stat w_stat;

    // Configuration registers; the user must send writes only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_len     <= LOCAL_LEN_RST;
            r_global_warmup <= GLOBAL_WARM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_LOCAL_LEN:     r_local_len     <= i_cfg_data[LEN_W-1:0];
                REG_GLOBAL_WARMUP: r_global_warmup <= i_cfg_data[WARM_W-1:0];
            endcase
        end
    end

    // Hold off new branches during the clear pass or while the queue is full.
    assign busy     = w_clearing || w_stat.full;
    assign w_accept = start && !busy;

    // Front: compute indexes and gshare readiness, advance global history.
    lgbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_warmup (r_global_warmup),
        .o_job    (w_job_in)
    );

    // Queue: decouple classification from the memory update.
    lgbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_head  (w_job_head),
        .o_stat  (w_stat)
    );

    // Back: read the tables, train, write back, drive the result beat.
    lgbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_head),
        .i_stat      (w_stat),
        .i_local_len (r_local_len),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== src/lgbp_checker.sv =====
// Port-level checks for the branch predictor top level, attached by bind.
// Depends on lgbp_pkg and local_and_gshare_branch_predictor.
`default_nettype none

module lgbp_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             busy,
    input wire             o_done,
    input lgbp_pkg::t_out  o_result
);
    import lgbp_pkg::*;

    // the clear pass keeps the block busy right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result beat right after reset");

    // each job passes through a fetch state and an update state, so result beats never come back to back
    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beats in consecutive cycles");

    // a predictor still warming up guesses not taken
    a_warmup_guess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.local_ready || !o_result.local_prediction) &&
                    (o_result.global_ready || !o_result.global_prediction)))
        else $error("taken guess during warm-up");

endmodule

bind local_and_gshare_branch_predictor lgbp_checker u_lgbp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
